// ===== rtl/kdlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kdlp_pkg;

    // Field widths of the item and of the configuration registers
    localparam int LEVELS_W   = 6;
    localparam int KEY_IDX_W  = 3;
    localparam int FILTER_W   = 8;
    localparam int COUNT_W    = 9;
    localparam int TIME_W     = 16;
    localparam int MASK_W     = 6;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_KEY_MASK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd3;

    // Register reset values
    localparam logic [FILTER_W-1:0] FILTER_TIME_RST   = 8'd5;
    localparam logic [TIME_W-1:0]   LONG_TIME_RST     = 16'd100;
    localparam logic [MASK_W-1:0]   LONG_KEY_MASK_RST = 6'd48;
    localparam logic [TIME_W-1:0]   REPEAT_PERIOD_RST = 16'd0;

    // Debounce counter starts at half of the reset filter time
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(FILTER_TIME_RST / 2);

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_LONG = 2'd2
    } event_type_t;

    // Per-key state carried by one cell of the ring
    typedef struct packed {
        logic [COUNT_W-1:0] debounce_count;
        logic               key_down_flag;
        logic [TIME_W-1:0]  hold_count;
        logic [TIME_W-1:0]  repeat_count;
    } key_state_t;

    // Up to two events made by one key on one tick
    typedef struct packed {
        logic        a_valid;
        event_type_t a_type;
        logic        b_valid;
        event_type_t b_type;
    } key_events_t;

endpackage
`default_nettype wire

// ===== rtl/kdlp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kdlp_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                shift_en,
    input  wire kdlp_pkg::key_state_t d,
    output kdlp_pkg::key_state_t      q
);

    kdlp_pkg::key_state_t state_reg;

    // Take the neighbor's key state on every ring advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.debounce_count <= kdlp_pkg::COUNT_RST;
            state_reg.key_down_flag  <= 1'b0;
            state_reg.hold_count     <= '0;
            state_reg.repeat_count   <= '0;
        end else if (shift_en) begin
            state_reg <= d;
        end
    end

    assign q = state_reg;

endmodule
`default_nettype wire

// ===== rtl/kdlp_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kdlp_update (
    input  wire kdlp_pkg::key_state_t             cur,
    input  wire logic                             pressed,
    input  wire logic                             long_en,
    input  wire logic [kdlp_pkg::FILTER_W-1:0]    filter_time,
    input  wire logic [kdlp_pkg::TIME_W-1:0]      long_time,
    input  wire logic [kdlp_pkg::TIME_W-1:0]      repeat_period,
    output kdlp_pkg::key_state_t                  nxt,
    output kdlp_pkg::key_events_t                 events
);

    logic [kdlp_pkg::COUNT_W-1:0] ft_ext;
    logic [kdlp_pkg::COUNT_W-1:0] ft_twice;
    logic [kdlp_pkg::TIME_W-1:0]  hold_inc;
    logic [kdlp_pkg::TIME_W-1:0]  rep_inc;

    assign ft_ext   = kdlp_pkg::COUNT_W'(filter_time);
    assign ft_twice = {filter_time, 1'b0};
    assign hold_inc = cur.hold_count + 16'd1;
    assign rep_inc  = cur.repeat_count + 16'd1;

    // Hysteresis debounce, press and release confirmation, hold and repeat counting
    always_comb begin
        nxt    = cur;
        events = '{a_valid: 1'b0, a_type: kdlp_pkg::EV_DOWN,
                   b_valid: 1'b0, b_type: kdlp_pkg::EV_DOWN};
        if (pressed) begin
            if (cur.debounce_count < ft_ext) begin
                nxt.debounce_count = ft_ext;
            end else if (cur.debounce_count < ft_twice) begin
                nxt.debounce_count = cur.debounce_count + 9'd1;
            end else begin
                if (!cur.key_down_flag) begin
                    nxt.key_down_flag = 1'b1;
                    events.a_valid    = 1'b1;
                    events.a_type     = kdlp_pkg::EV_DOWN;
                end
                if (long_time != '0 && long_en) begin
                    if (cur.hold_count < long_time) begin
                        nxt.hold_count = hold_inc;
                        if (hold_inc == long_time) begin
                            events.b_valid = 1'b1;
                            events.b_type  = kdlp_pkg::EV_LONG;
                        end
                    end else if (repeat_period != '0) begin
                        if (rep_inc >= repeat_period) begin
                            nxt.repeat_count = '0;
                            events.b_valid   = 1'b1;
                            events.b_type    = kdlp_pkg::EV_DOWN;
                        end else begin
                            nxt.repeat_count = rep_inc;
                        end
                    end
                end
            end
        end else begin
            if (cur.debounce_count > ft_ext) begin
                nxt.debounce_count = ft_ext;
            end else if (cur.debounce_count != '0) begin
                nxt.debounce_count = cur.debounce_count - 9'd1;
            end else if (cur.key_down_flag) begin
                nxt.key_down_flag = 1'b0;
                events.a_valid    = 1'b1;
                events.a_type     = kdlp_pkg::EV_UP;
            end
            nxt.hold_count   = '0;
            nxt.repeat_count = '0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/key_debounce_long_press_events_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Key scan debouncer with long-press and auto-repeat events, one update unit on a key ring.
// Each accepted item is scanned key by key through the ring, then the held-back final event,
// if any, is flushed with m_tlast; a key with two events takes an extra step, and output stalls hold the scan.
// s_tready is high only in idle, so a new item is taken only after the last one is done.
// Synchronous active-low reset sets the configuration registers to their defaults, debounce
// counters to half the reset filter time and all other key state to zero.
module key_debounce_long_press_events_core #(
    parameter int NUM_KEYS = 6
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: key_levels [5:0], zeros [7:6]
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,
    // m_tdata: key_index [2:0], zeros [7:3]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,
    // m_tuser: event_type [1:0]
    output logic [1:0]                              m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_wr_en,
    input  wire logic [kdlp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [kdlp_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic [KW-1:0]       key_cnt_reg, key_cnt_next;
    logic                phase_reg, phase_next;
    logic [NUM_KEYS-1:0] levels_reg, levels_next;
    logic [NUM_KEYS-1:0] mask_reg, mask_next;

    logic                                 pend_valid_reg, pend_valid_next;
    logic [kdlp_pkg::KEY_IDX_W-1:0]       pend_key_reg, pend_key_next;
    kdlp_pkg::event_type_t                pend_type_reg, pend_type_next;

    logic                                 m_valid_reg, m_valid_next;
    logic [kdlp_pkg::KEY_IDX_W-1:0]       m_key_reg, m_key_next;
    kdlp_pkg::event_type_t                m_type_reg, m_type_next;
    logic                                 m_last_reg, m_last_next;

    logic [kdlp_pkg::FILTER_W-1:0] filter_time_reg;
    logic [kdlp_pkg::TIME_W-1:0]   long_time_reg;
    logic [kdlp_pkg::MASK_W-1:0]   long_key_mask_reg;
    logic [kdlp_pkg::TIME_W-1:0]   repeat_period_reg;

    kdlp_pkg::key_state_t  ring_q [NUM_KEYS];
    kdlp_pkg::key_state_t  head_next;
    kdlp_pkg::key_events_t head_events;
    logic                  key_done;
    logic                  out_free;
    logic                  cur_valid;
    kdlp_pkg::event_type_t cur_type;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_time_reg   <= kdlp_pkg::FILTER_TIME_RST;
            long_time_reg     <= kdlp_pkg::LONG_TIME_RST;
            long_key_mask_reg <= kdlp_pkg::LONG_KEY_MASK_RST;
            repeat_period_reg <= kdlp_pkg::REPEAT_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                kdlp_pkg::CFG_FILTER_TIME:
                    filter_time_reg <= cfg_wr_data[kdlp_pkg::FILTER_W-1:0];
                kdlp_pkg::CFG_LONG_TIME:
                    long_time_reg <= cfg_wr_data;
                kdlp_pkg::CFG_LONG_KEY_MASK:
                    long_key_mask_reg <= cfg_wr_data[kdlp_pkg::MASK_W-1:0];
                kdlp_pkg::CFG_REPEAT_PERIOD:
                    repeat_period_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Ring of key cells: cell 0 is the head, the updated head re-enters at the tail
    for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
        kdlp_pkg::key_state_t cell_d;
        if (i == NUM_KEYS - 1) begin : g_tail
            assign cell_d = head_next;
        end else begin : g_mid
            assign cell_d = ring_q[i+1];
        end
        kdlp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (key_done),
            .d        (cell_d),
            .q        (ring_q[i])
        );
    end

    kdlp_update u_update (
        .cur           (ring_q[0]),
        .pressed       (levels_reg[0]),
        .long_en       (mask_reg[0]),
        .filter_time   (filter_time_reg),
        .long_time     (long_time_reg),
        .repeat_period (repeat_period_reg),
        .nxt           (head_next),
        .events        (head_events)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign cur_valid = phase_reg ? head_events.b_valid : head_events.a_valid;
    assign cur_type  = phase_reg ? head_events.b_type  : head_events.a_type;

    // Scan sequencer: hold one event back so the final one can carry last
    always_comb begin
        state_next      = state_reg;
        key_cnt_next    = key_cnt_reg;
        phase_next      = phase_reg;
        levels_next     = levels_reg;
        mask_next       = mask_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_type_next  = pend_type_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_key_next      = m_key_reg;
        m_type_next     = m_type_reg;
        m_last_next     = m_last_reg;
        key_done        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    levels_next  = NUM_KEYS'(s_tdata[kdlp_pkg::LEVELS_W-1:0]);
                    mask_next    = NUM_KEYS'(long_key_mask_reg);
                    key_cnt_next = '0;
                    phase_next   = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!cur_valid || !pend_valid_reg || out_free) begin
                    if (cur_valid) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_key_next   = pend_key_reg;
                            m_type_next  = pend_type_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_key_next   = kdlp_pkg::KEY_IDX_W'(key_cnt_reg);
                        pend_type_next  = cur_type;
                    end
                    if (!phase_reg && head_events.b_valid) begin
                        phase_next = 1'b1;
                    end else begin
                        // Advance the ring to the next key
                        key_done     = 1'b1;
                        phase_next   = 1'b0;
                        levels_next  = levels_reg >> 1;
                        mask_next    = mask_reg >> 1;
                        key_cnt_next = key_cnt_reg + 1'b1;
                        if (key_cnt_reg == LAST_KEY) begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_key_next      = pend_key_reg;
                    m_type_next     = pend_type_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            key_cnt_reg    <= '0;
            phase_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            key_cnt_reg    <= key_cnt_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        levels_reg    <= levels_next;
        mask_reg      <= mask_next;
        pend_key_reg  <= pend_key_next;
        pend_type_reg <= pend_type_next;
        m_key_reg     <= m_key_next;
        m_type_reg    <= m_type_next;
        m_last_reg    <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_key_reg};
    assign m_tuser  = m_type_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// ===== test/key_event_checker.sv =====
`timescale 1ns / 1ps
module key_event_checker #(
    parameter int NUM_KEYS = 6
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [7:0]                      m_tdata,
    input  wire logic [1:0]                      m_tuser,
    input  wire logic                            m_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    typedef struct packed {
        logic [kdlp_pkg::KEY_IDX_W-1:0] key_idx;
        kdlp_pkg::event_type_t          kind;
        logic                           last;
    } key_event_t;

    // Shadow copy of the registers
    logic [kdlp_pkg::FILTER_W-1:0] debounce_ticks;
    logic [kdlp_pkg::TIME_W-1:0]   hold_limit;
    logic [kdlp_pkg::MASK_W-1:0]   long_enable;
    logic [kdlp_pkg::TIME_W-1:0]   repeat_ticks;

    // Shadow copy of the per-key state
    logic [kdlp_pkg::COUNT_W-1:0] bounce_cnt [NUM_KEYS];
    logic                         is_down    [NUM_KEYS];
    logic [kdlp_pkg::TIME_W-1:0]  held_ticks [NUM_KEYS];
    logic [kdlp_pkg::TIME_W-1:0]  rep_cnt    [NUM_KEYS];

    key_event_t tick_events[$];
    key_event_t expected_events[$];

    function automatic void emit_event(input int k, input kdlp_pkg::event_type_t kind);
        key_event_t ev;
        ev.key_idx = kdlp_pkg::KEY_IDX_W'(k);
        ev.kind    = kind;
        ev.last    = 1'b0;
        tick_events.push_back(ev);
    endfunction

    // Advance every key by one scan tick and queue the events it makes
    function automatic void predict_events(input logic [kdlp_pkg::LEVELS_W-1:0] levels);
        key_event_t ev;
        int         full;
        tick_events.delete();
        full = 2 * int'(debounce_ticks);
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (k < kdlp_pkg::LEVELS_W && levels[k]) begin
                if (int'(bounce_cnt[k]) < int'(debounce_ticks)) begin
                    bounce_cnt[k] = kdlp_pkg::COUNT_W'(debounce_ticks);
                end else if (int'(bounce_cnt[k]) < full) begin
                    bounce_cnt[k] = bounce_cnt[k] + 1'b1;
                end else begin
                    if (!is_down[k]) begin
                        is_down[k] = 1'b1;
                        emit_event(k, kdlp_pkg::EV_DOWN);
                    end
                    if (hold_limit != 0 && long_enable[k]) begin
                        if (held_ticks[k] < hold_limit) begin
                            held_ticks[k] = held_ticks[k] + 1'b1;
                            if (held_ticks[k] == hold_limit)
                                emit_event(k, kdlp_pkg::EV_LONG);
                        end else if (repeat_ticks != 0) begin
                            rep_cnt[k] = rep_cnt[k] + 1'b1;
                            if (rep_cnt[k] >= repeat_ticks) begin
                                rep_cnt[k] = '0;
                                emit_event(k, kdlp_pkg::EV_DOWN);
                            end
                        end
                    end
                end
            end else begin
                if (bounce_cnt[k] > kdlp_pkg::COUNT_W'(debounce_ticks)) begin
                    bounce_cnt[k] = kdlp_pkg::COUNT_W'(debounce_ticks);
                end else if (bounce_cnt[k] != 0) begin
                    bounce_cnt[k] = bounce_cnt[k] - 1'b1;
                end else if (is_down[k]) begin
                    is_down[k] = 1'b0;
                    emit_event(k, kdlp_pkg::EV_UP);
                end
                held_ticks[k] = '0;
                rep_cnt[k]    = '0;
            end
        end
        // Flag the final event of the tick
        foreach (tick_events[i]) begin
            ev      = tick_events[i];
            ev.last = (i == tick_events.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    always @(posedge aclk) begin : watch
        key_event_t                     want;
        logic [kdlp_pkg::KEY_IDX_W-1:0] got_key;
        kdlp_pkg::event_type_t          got_kind;
        if (!aresetn) begin
            debounce_ticks = kdlp_pkg::FILTER_TIME_RST;
            hold_limit     = kdlp_pkg::LONG_TIME_RST;
            long_enable    = kdlp_pkg::LONG_KEY_MASK_RST;
            repeat_ticks   = kdlp_pkg::REPEAT_PERIOD_RST;
            for (int k = 0; k < NUM_KEYS; k++) begin
                bounce_cnt[k] = kdlp_pkg::COUNT_RST;
                is_down[k]    = 1'b0;
                held_ticks[k] = '0;
                rep_cnt[k]    = '0;
            end
            expected_events.delete();
        end else begin
            // Compare each result item with the oldest expected event
            if (m_tvalid && m_tready) begin
                got_key  = m_tdata[2:0];
                got_kind = kdlp_pkg::event_type_t'(m_tuser);
                if (expected_events.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected key event: key %0d type %0d last %0b",
                             $time, got_key, got_kind, m_tlast);
                end else begin
                    want = expected_events.pop_front();
                    checked++;
                    if (got_key !== want.key_idx || got_kind !== want.kind
                            || m_tlast !== want.last) begin
                        fail_count++;
                        $display("%0t: key event mismatch: expected key %0d type %0d last %0b, %s",
                                 $time, want.key_idx, want.kind, want.last, "got below");
                        $display("%0t:   actual key %0d type %0d last %0b",
                                 $time, got_key, got_kind, m_tlast);
                    end
                end
            end
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    kdlp_pkg::CFG_FILTER_TIME:
                        debounce_ticks = cfg_wr_data[kdlp_pkg::FILTER_W-1:0];
                    kdlp_pkg::CFG_LONG_TIME:
                        hold_limit = cfg_wr_data[kdlp_pkg::TIME_W-1:0];
                    kdlp_pkg::CFG_LONG_KEY_MASK:
                        long_enable = cfg_wr_data[kdlp_pkg::MASK_W-1:0];
                    kdlp_pkg::CFG_REPEAT_PERIOD:
                        repeat_ticks = cfg_wr_data[kdlp_pkg::TIME_W-1:0];
                    default: ;
                endcase
            end
            // Predict the events of each accepted scan item
            if (s_tvalid && s_tready)
                predict_events(s_tdata[kdlp_pkg::LEVELS_W-1:0]);
        end
        pending = expected_events.size();
    end

endmodule

// ===== test/key_debounce_long_press_events_core_test.sv =====
`timescale 1ns / 1ps
module key_debounce_long_press_events_core_test;

    localparam int NUM_KEYS        = 6;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;

    // Directed scan items, first item in the lowest bits
    localparam int DIRECTED_N = 16;
    localparam logic [DIRECTED_N*kdlp_pkg::LEVELS_W-1:0] DIRECTED_LEVELS = {
        6'h00, 6'h3F, 6'h00, 6'h00, 6'h00, 6'h15, 6'h15, 6'h15,
        6'h2A, 6'h2A, 6'h2A, 6'h00, 6'h00, 6'h00, 6'h3F, 6'h3F
    };

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            s_tvalid     = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata      = '0;
    logic                            m_tvalid;
    logic                            m_tready     = 1'b0;
    logic [7:0]                      m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_wr_en    = 1'b0;
    logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wr_data  = '0;

    int   fail_count;
    int   pending;
    int   checked;
    int   items_sent     = 0;
    int   phases_run     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles    = 0;
    int   hold_left      = 0;
    logic hold_off_req   = 1'b0;
    logic hold_off_seen  = 1'b0;

    key_debounce_long_press_events_core #(
        .NUM_KEYS(NUM_KEYS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data)
    );

    key_event_checker #(
        .NUM_KEYS(NUM_KEYS)
    ) i_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count),
        .pending(pending),
        .checked(checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Drive the result ready: long hold-off on request, else random stalls
    always @(negedge aclk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_left     <= HOLD_OFF_CYCLES;
            m_tready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no item moved for %0d cycles, %0d events pending",
                     $time, idle_cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one scan item after random idle cycles and hold it until accepted
    task automatic send_tick(input logic [kdlp_pkg::LEVELS_W-1:0] levels);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, levels};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drop valid, wait for all expected events, then let the scan finish
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_registers(input logic [kdlp_pkg::CFG_DATA_W-1:0] filter_t,
                                   input logic [kdlp_pkg::CFG_DATA_W-1:0] long_t,
                                   input logic [kdlp_pkg::CFG_DATA_W-1:0] mask,
                                   input logic [kdlp_pkg::CFG_DATA_W-1:0] repeat_t);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= kdlp_pkg::CFG_FILTER_TIME;
        cfg_wr_data  <= filter_t;
        @(negedge aclk);
        cfg_wr_index <= kdlp_pkg::CFG_LONG_TIME;
        cfg_wr_data  <= long_t;
        @(negedge aclk);
        cfg_wr_index <= kdlp_pkg::CFG_LONG_KEY_MASK;
        cfg_wr_data  <= mask;
        @(negedge aclk);
        cfg_wr_index <= kdlp_pkg::CFG_REPEAT_PERIOD;
        cfg_wr_data  <= repeat_t;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        phases_run++;
    endtask

    // Hold random key patterns for random runs, with an occasional bounce
    task automatic send_runs(input int count, input int max_run);
        logic [kdlp_pkg::LEVELS_W-1:0] pattern;
        logic [kdlp_pkg::LEVELS_W-1:0] levels;
        int                            run_len;
        int                            sent;
        sent = 0;
        while (sent < count) begin
            pattern = kdlp_pkg::LEVELS_W'($urandom_range(0, 63));
            run_len = $urandom_range(1, max_run);
            for (int j = 0; j < run_len && sent < count; j++) begin
                levels = pattern;
                if ($urandom_range(0, 9) == 0)
                    levels[$urandom_range(0, kdlp_pkg::LEVELS_W - 1)] ^= 1'b1;
                send_tick(levels);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int filter_t, input int long_t, input int mask,
                             input int repeat_t, input int send_pct, input int recv_pct,
                             input int count, input int max_run, input bit hold_off);
        settle();
        write_registers(kdlp_pkg::CFG_DATA_W'(filter_t), kdlp_pkg::CFG_DATA_W'(long_t),
                        kdlp_pkg::CFG_DATA_W'(mask), kdlp_pkg::CFG_DATA_W'(repeat_t));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold_off) begin
            @(posedge aclk);
            hold_off_req = ~hold_off_req;
            @(negedge aclk);
        end
        send_runs(count, max_run);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: all keys at once with down and long on one tick, repeats,
        // releases, and alternating key halves
        write_registers(16'd1, 16'd1, 16'd63, 16'd1);
        for (int i = 0; i < DIRECTED_N; i++)
            send_tick(DIRECTED_LEVELS[i*kdlp_pkg::LEVELS_W +: kdlp_pkg::LEVELS_W]);

        // Random phases: register settings, idle modes and run lengths
        run_phase(2,     4,     63,   2,     0,  0,  50, 16, 1'b0);
        run_phase(0,     3,     8'h15, 1,    73, 0,  50, 10, 1'b0);
        run_phase(1,     6,     8'h2A, 3,    0,  73, 50, 16, 1'b0);
        run_phase(3,     2,     63,   0,     17, 17, 50, 14, 1'b0);
        run_phase(255,   65535, 63,   65535, 0,  0,  16, 15, 1'b0);
        run_phase(1,     0,     0,    5,     0,  0,  50, 6,  1'b1);
        run_phase(1,     2,     63,   1,     17, 17, 50, 12, 1'b0);

        settle();
        $display("Summary: %0d scan items over %0d register settings, %0d key events compared",
                 items_sent, phases_run, checked);
        $display("Summary: zero and maximum filter, long press off and max, repeat, hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kdlp_pkg.sv
rtl/kdlp_cell.sv
rtl/kdlp_update.sv
rtl/key_debounce_long_press_events_core.sv
test/key_event_checker.sv
test/key_debounce_long_press_events_core_test.sv
